// ===== rtl/core/i2cmb_pkg.sv =====
package i2cmb_pkg;

  localparam int TIMER_WIDTH_DEFAULT = 16;

  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_START    = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_WRITE    = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;
  localparam logic [2:0] CMD_WAIT_ACK = 3'd5;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HALF_PERIOD    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACK_POLL_LIMIT = 2'd1;

  localparam logic [15:0] HALF_PERIOD_RESET    = 16'd5;
  localparam logic [15:0] ACK_POLL_LIMIT_RESET = 16'd300;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic       timed_out;
  } result_t;

  typedef struct packed {
    logic                       valid;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [15:0]                data;
  } cfg_wr_t;

endpackage

// ===== rtl/core/i2c_master_bit_engine.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_stall    command, write_data, send_ack, sda_in
// out      out_valid / out_stall  scl, sda_level, sda_drive, busy_res, done_res,
//                                 rx_byte, ack_received, timed_out
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock is accepted while the input is not stalled, and one result
// item per clock is delivered while out_stall is low. An item passes through an
// input register, then the phase logic into a two-entry output buffer. Reset is
// synchronous and returns the engine to idle with SCL and SDA high and driven.
// The input stalls only while both output entries are full; cfg_ready is always high.
module i2c_master_bit_engine #(
  parameter int TIMER_WIDTH = i2cmb_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [2:0]                            command,
  input  logic [7:0]                            write_data,
  input  logic                                  send_ack,
  input  logic                                  sda_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  scl,
  output logic                                  sda_level,
  output logic                                  sda_drive,
  output logic                                  busy_res,
  output logic                                  done_res,
  output logic [7:0]                            rx_byte,
  output logic                                  ack_received,
  output logic                                  timed_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [i2cmb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [15:0]                           cfg_data
);

  logic               stage_valid;
  i2cmb_pkg::item_t   stage_item;
  logic               obuf_ready;
  logic               fire;
  i2cmb_pkg::cfg_wr_t cfg;
  i2cmb_pkg::result_t result;
  i2cmb_pkg::result_t out_data;

  assign fire      = stage_valid & obuf_ready;
  assign in_stall  = stage_valid & ~obuf_ready;
  assign cfg_ready = 1'b1;
  assign cfg       = '{valid: cfg_valid, index: cfg_index, data: cfg_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
      if (in_valid) begin
        stage_item <= '{command: command, write_data: write_data,
                        send_ack: send_ack, sda_in: sda_in};
      end
    end
  end

  i2cmb_engine #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (stage_item),
    .cfg    (cfg),
    .result (result)
  );

  i2cmb_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (result),
    .ready     (obuf_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign scl          = out_data.scl;
  assign sda_level    = out_data.sda_level;
  assign sda_drive    = out_data.sda_drive;
  assign busy_res     = out_data.busy_res;
  assign done_res     = out_data.done_res;
  assign rx_byte      = out_data.rx_byte;
  assign ack_received = out_data.ack_received;
  assign timed_out    = out_data.timed_out;

endmodule

// ===== rtl/core/i2cmb_engine.sv =====
module i2cmb_engine #(
  parameter int TIMER_WIDTH = i2cmb_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  i2cmb_pkg::item_t    item,
  input  i2cmb_pkg::cfg_wr_t  cfg,
  output i2cmb_pkg::result_t  result
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_HI, PH_ST_LO, PH_SP_LO, PH_SP_HI, PH_WR_HI, PH_WR_LO,
    PH_RD_HI, PH_RD_LO, PH_RD_AS, PH_RD_AH, PH_WA_POLL, PH_TO_PREP, PH_DONE
  } phase_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } pins_t;

  localparam logic [TIMER_WIDTH-1:0] TIMER_ONE = TIMER_WIDTH'(1);

  logic [15:0]            half_period;
  logic [15:0]            ack_poll_limit;
  phase_t                 phase, phase_next;
  logic [3:0]             bit_index, bit_index_next;
  logic [TIMER_WIDTH-1:0] delay_count, delay_count_next;
  logic [15:0]            poll_count, poll_count_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic                   pending_ack, pending_ack_next;
  pins_t                  pin_levels, pin_levels_next;
  pins_t                  final_pins, final_pins_next;
  logic                   ack_received, ack_received_next;
  logic                   timed_out, timed_out_next;
  logic [7:0]             last_read, last_read_next;
  logic                   busy, done;

  logic [TIMER_WIDTH+15:0] half_ext;
  logic [TIMER_WIDTH-1:0]  h_masked;
  logic [TIMER_WIDTH-1:0]  h_eff;
  logic                    seg_end;
  logic [TIMER_WIDTH-1:0]  delay_inc;
  logic [3:0]              bit_inc;
  logic                    ackbit;

  assign half_ext  = {{TIMER_WIDTH{1'b0}}, half_period};
  assign h_masked  = half_ext[TIMER_WIDTH-1:0];
  assign h_eff     = (h_masked == '0) ? TIMER_ONE : h_masked;
  assign seg_end   = ({1'b0, delay_count} + {1'b0, TIMER_ONE}) >= {1'b0, h_eff};
  assign delay_inc = delay_count + TIMER_ONE;
  assign bit_inc   = bit_index + 4'd1;
  assign ackbit    = ~pending_ack;

  always_comb begin
    phase_next        = phase;
    bit_index_next    = bit_index;
    delay_count_next  = delay_count;
    poll_count_next   = poll_count;
    shift_byte_next   = shift_byte;
    pending_ack_next  = pending_ack;
    pin_levels_next   = pin_levels;
    final_pins_next   = final_pins;
    ack_received_next = ack_received;
    timed_out_next    = timed_out;
    last_read_next    = last_read;
    busy              = 1'b0;
    done              = 1'b0;

    if (phase == PH_IDLE) begin
      if (item.command >= i2cmb_pkg::CMD_START && item.command <= i2cmb_pkg::CMD_WAIT_ACK) begin
        busy             = 1'b1;
        delay_count_next = '0;
        bit_index_next   = 4'd0;
        poll_count_next  = 16'd0;
        case (item.command)
          i2cmb_pkg::CMD_START: begin
            pin_levels_next = '{scl: 1'b0, sda: 1'b1, drv: 1'b1};
            final_pins_next = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
            phase_next      = PH_ST_HI;
          end
          i2cmb_pkg::CMD_STOP: begin
            pin_levels_next = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
            final_pins_next = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
            phase_next      = PH_SP_LO;
          end
          i2cmb_pkg::CMD_WRITE: begin
            shift_byte_next = item.write_data;
            pin_levels_next = '{scl: 1'b0, sda: item.write_data[7], drv: 1'b1};
            final_pins_next = '{scl: 1'b0, sda: item.write_data[0], drv: 1'b1};
            phase_next      = PH_WR_HI;
          end
          i2cmb_pkg::CMD_READ: begin
            shift_byte_next  = 8'd0;
            pending_ack_next = item.send_ack;
            pin_levels_next  = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
            final_pins_next  = '{scl: 1'b0, sda: ~item.send_ack, drv: 1'b1};
            phase_next       = PH_RD_HI;
          end
          default: begin
            pin_levels_next = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
            final_pins_next = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
            phase_next      = PH_WA_POLL;
          end
        endcase
      end
    end else if (phase == PH_DONE) begin
      pin_levels_next = final_pins;
      phase_next      = PH_IDLE;
      done            = 1'b1;
    end else begin
      busy = 1'b1;
      case (phase)
        PH_ST_HI: begin
          pin_levels_next = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
          if (seg_end) begin
            delay_count_next = '0;
            phase_next       = PH_ST_LO;
          end else begin
            delay_count_next = delay_inc;
          end
        end
        PH_ST_LO: begin
          pin_levels_next = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
          if (seg_end) begin
            delay_count_next = '0;
            phase_next       = PH_DONE;
          end else begin
            delay_count_next = delay_inc;
          end
        end
        PH_SP_LO: begin
          pin_levels_next = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
          if (seg_end) begin
            delay_count_next = '0;
            phase_next       = PH_SP_HI;
          end else begin
            delay_count_next = delay_inc;
          end
        end
        PH_SP_HI: begin
          pin_levels_next = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
          if (seg_end) begin
            delay_count_next = '0;
            phase_next       = PH_DONE;
          end else begin
            delay_count_next = delay_inc;
          end
        end
        PH_WR_HI: begin
          pin_levels_next = '{scl: 1'b1, sda: shift_byte[7], drv: 1'b1};
          if (seg_end) begin
            delay_count_next = '0;
            phase_next       = PH_WR_LO;
          end else begin
            delay_count_next = delay_inc;
          end
        end
        PH_WR_LO: begin
          pin_levels_next = '{scl: 1'b0, sda: shift_byte[7], drv: 1'b1};
          if (seg_end) begin
            delay_count_next = '0;
            shift_byte_next  = {shift_byte[6:0], 1'b0};
            bit_index_next   = bit_inc;
            phase_next       = (bit_inc >= 4'd8) ? PH_DONE : PH_WR_HI;
          end else begin
            delay_count_next = delay_inc;
          end
        end
        PH_RD_HI: begin
          pin_levels_next = '{scl: 1'b1, sda: 1'b1, drv: 1'b0};
          if (delay_count == '0) begin
            shift_byte_next = {shift_byte[6:0], item.sda_in};
          end
          if (seg_end) begin
            delay_count_next = '0;
            phase_next       = PH_RD_LO;
          end else begin
            delay_count_next = delay_inc;
          end
        end
        PH_RD_LO: begin
          pin_levels_next = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
          if (seg_end) begin
            delay_count_next = '0;
            bit_index_next   = bit_inc;
            if (bit_inc >= 4'd8) begin
              last_read_next = shift_byte;
              phase_next     = PH_RD_AS;
            end else begin
              phase_next = PH_RD_HI;
            end
          end else begin
            delay_count_next = delay_inc;
          end
        end
        PH_RD_AS: begin
          pin_levels_next  = '{scl: 1'b0, sda: ackbit, drv: 1'b1};
          delay_count_next = '0;
          phase_next       = PH_RD_AH;
        end
        PH_RD_AH: begin
          pin_levels_next = '{scl: 1'b1, sda: ackbit, drv: 1'b1};
          if (seg_end) begin
            delay_count_next = '0;
            phase_next       = PH_DONE;
          end else begin
            delay_count_next = delay_inc;
          end
        end
        PH_WA_POLL: begin
          pin_levels_next = '{scl: 1'b1, sda: 1'b1, drv: 1'b0};
          if (!item.sda_in) begin
            ack_received_next = 1'b1;
            timed_out_next    = 1'b0;
            phase_next        = PH_DONE;
          end else if (poll_count >= ack_poll_limit) begin
            ack_received_next = 1'b0;
            timed_out_next    = 1'b1;
            final_pins_next   = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
            phase_next        = PH_TO_PREP;
          end else begin
            poll_count_next = poll_count + 16'd1;
          end
        end
        PH_TO_PREP: begin
          pin_levels_next  = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
          delay_count_next = '0;
          phase_next       = PH_SP_LO;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    result.scl          = pin_levels_next.scl;
    result.sda_level    = pin_levels_next.drv ? pin_levels_next.sda : 1'b1;
    result.sda_drive    = pin_levels_next.drv;
    result.busy_res     = busy;
    result.done_res     = done;
    result.rx_byte      = last_read_next;
    result.ack_received = ack_received_next;
    result.timed_out    = timed_out_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period    <= i2cmb_pkg::HALF_PERIOD_RESET;
      ack_poll_limit <= i2cmb_pkg::ACK_POLL_LIMIT_RESET;
      phase          <= PH_IDLE;
      bit_index      <= 4'd0;
      delay_count    <= '0;
      poll_count     <= 16'd0;
      shift_byte     <= 8'd0;
      pending_ack    <= 1'b0;
      pin_levels     <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      final_pins     <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      ack_received   <= 1'b0;
      timed_out      <= 1'b0;
      last_read      <= 8'd0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          i2cmb_pkg::CFG_HALF_PERIOD:    half_period    <= cfg.data;
          i2cmb_pkg::CFG_ACK_POLL_LIMIT: ack_poll_limit <= cfg.data;
          default: ;
        endcase
      end
      if (fire) begin
        phase        <= phase_next;
        bit_index    <= bit_index_next;
        delay_count  <= delay_count_next;
        poll_count   <= poll_count_next;
        shift_byte   <= shift_byte_next;
        pending_ack  <= pending_ack_next;
        pin_levels   <= pin_levels_next;
        final_pins   <= final_pins_next;
        ack_received <= ack_received_next;
        timed_out    <= timed_out_next;
        last_read    <= last_read_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_idle_timer_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> delay_count == '0)
    else $error("Delay counter not cleared while idle.");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_IDLE && item.command >= i2cmb_pkg::CMD_START &&
    item.command <= i2cmb_pkg::CMD_WAIT_ACK |=> phase != PH_IDLE)
    else $error("Accepted command did not leave idle.");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_DONE |=> phase == PH_IDLE)
    else $error("Completion did not return to idle.");
`endif

endmodule

// ===== rtl/core/i2cmb_obuf.sv =====
module i2cmb_obuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  i2cmb_pkg::result_t  push_data,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cmb_pkg::result_t  out_data
);

  logic               skid_valid;
  i2cmb_pkg::result_t skid_data;
  logic               pop;

  assign ready = ~skid_valid;
  assign pop   = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("Skid entry held with empty output register.");
`endif

endmodule
